[design/dltq_pkg.sv]
// shared types, codes and index helpers for the delta list timer queue
package dltq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] KIND_EXPIRED  = 3'd0;
  localparam logic [2:0] KIND_STARTED  = 3'd1;
  localparam logic [2:0] KIND_CANCELED = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] seqnum;
    logic [31:0] delta;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] port;
    logic [31:0] seqnum;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_CMP,
    ST_S_SRD,
    ST_S_SWR,
    ST_S_NEW,
    ST_C_RD,
    ST_C_CMP,
    ST_C_SRD,
    ST_C_SWR,
    ST_T_RD,
    ST_T_CHK,
    ST_EMIT
  } state_e;

  // logical position behind the ring head to physical entry index
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
    logic [IDX_W:0] s;
    s = (IDX_W+1)'(head) + (IDX_W+1)'(pos);
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

[design/dltq_core.sv]
// sequencer and entry memory that walk, shift and pop the delta list
module dltq_core import dltq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_op_i,
  input  logic [15:0] in_port_i,
  input  logic [31:0] in_seqnum_i,
  input  logic [31:0] in_amount_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] l_q, l_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [31:0] before_q, before_d;
  logic [31:0] acc_q, acc_d;
  logic first_q, first_d;
  logic pend_v_q, pend_v_d;
  logic [15:0] pend_port_q, pend_port_d;
  logic [31:0] pend_seq_q, pend_seq_d;
  logic [2:0] kind_q, kind_d;
  logic [15:0] port_q, port_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] amount_q, amount_d;

  entry_t mem [DEPTH];
  entry_t rd_q;
  logic we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata;

  logic [32:0] through;
  logic [32:0] merged;
  logic [31:0] tick_delta;
  logic [31:0] head_delta;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign through    = {1'b0, before_q} + {1'b0, rd_q.delta};
  assign merged     = {1'b0, acc_q} + {1'b0, rd_q.delta};
  assign tick_delta = (rd_q.delta > amount_q) ? rd_q.delta - amount_q : '0;
  assign head_delta = first_q ? tick_delta : rd_q.delta;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    l_d         = l_q;
    pos_d       = pos_q;
    before_d    = before_q;
    acc_d       = acc_q;
    first_d     = first_q;
    pend_v_d    = pend_v_q;
    pend_port_d = pend_port_q;
    pend_seq_d  = pend_seq_q;
    kind_d      = kind_q;
    port_d      = port_q;
    seq_d       = seq_q;
    amount_d    = amount_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = phys_idx(head_q, l_q);
    raddr       = phys_idx(head_q, l_q);
    wdata       = rd_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: kind_q, port: port_q, seqnum: seq_q, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          port_d   = in_port_i;
          seq_d    = in_seqnum_i;
          amount_d = in_amount_i;
          l_d      = '0;
          before_d = '0;
          first_d  = 1'b1;
          pend_v_d = 1'b0;
          case (in_op_i)
            OP_START: begin
              if (count_q == CNT_W'(DEPTH)) begin
                kind_d  = KIND_FULL;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_S_RD;
              end
            end
            OP_CANCEL: state_d = ST_C_RD;
            OP_TICK:   state_d = ST_T_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      // start: walk the running sum
      ST_S_RD: begin
        if (l_q == count_q) begin
          pos_d   = l_q;
          state_d = ST_S_SRD;
        end else begin
          re      = 1'b1;
          state_d = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if ({1'b0, amount_q} <= through) begin
          pos_d   = l_q;
          acc_d   = 32'(through - {1'b0, amount_q});
          l_d     = count_q;
          state_d = ST_S_SRD;
        end else begin
          before_d = through[31:0];
          l_d      = l_q + 1'b1;
          state_d  = ST_S_RD;
        end
      end
      // start: move entries up one place, top first
      ST_S_SRD: begin
        if (l_q == pos_q) begin
          state_d = ST_S_NEW;
        end else begin
          re      = 1'b1;
          raddr   = phys_idx(head_q, l_q - 1'b1);
          state_d = ST_S_SWR;
        end
      end
      ST_S_SWR: begin
        we = 1'b1;
        if (l_q - 1'b1 == pos_q) begin
          wdata.delta = acc_q;
        end
        l_d     = l_q - 1'b1;
        state_d = ST_S_SRD;
      end
      ST_S_NEW: begin
        we      = 1'b1;
        waddr   = phys_idx(head_q, pos_q);
        wdata   = '{port: port_q, seqnum: seq_q, delta: amount_q - before_q};
        count_d = count_q + 1'b1;
        kind_d  = KIND_STARTED;
        state_d = ST_EMIT;
      end

      // cancel: search for port and sequence number
      ST_C_RD: begin
        if (l_q == count_q) begin
          kind_d  = KIND_NOTFOUND;
          state_d = ST_EMIT;
        end else begin
          re      = 1'b1;
          state_d = ST_C_CMP;
        end
      end
      ST_C_CMP: begin
        if (rd_q.port == port_q && rd_q.seqnum == seq_q) begin
          pos_d   = l_q;
          acc_d   = rd_q.delta;
          state_d = ST_C_SRD;
        end else begin
          l_d     = l_q + 1'b1;
          state_d = ST_C_RD;
        end
      end
      // cancel: close the gap, merging the delta into the successor
      ST_C_SRD: begin
        if (l_q + 1'b1 == count_q) begin
          count_d = count_q - 1'b1;
          kind_d  = KIND_CANCELED;
          state_d = ST_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = phys_idx(head_q, l_q + 1'b1);
          state_d = ST_C_SWR;
        end
      end
      ST_C_SWR: begin
        we = 1'b1;
        if (l_q == pos_q) begin
          wdata.delta = merged[32] ? '1 : merged[31:0];
        end
        l_d     = l_q + 1'b1;
        state_d = ST_C_SRD;
      end

      // tick: trim the head, then pop zero-delta entries
      ST_T_RD: begin
        res_o = '{kind: KIND_EXPIRED, port: pend_port_q, seqnum: pend_seq_q, last: 1'b1};
        if (count_q == '0) begin
          res_valid_o = pend_v_q;
          if (!pend_v_q || res_ready_i) begin
            state_d = ST_IDLE;
          end
        end else begin
          re      = 1'b1;
          raddr   = head_q;
          state_d = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        if (head_delta == '0) begin
          res_o = '{kind: KIND_EXPIRED, port: pend_port_q, seqnum: pend_seq_q, last: 1'b0};
          res_valid_o = pend_v_q;
          if (!pend_v_q || res_ready_i) begin
            pend_v_d    = 1'b1;
            pend_port_d = rd_q.port;
            pend_seq_d  = rd_q.seqnum;
            head_d      = wrap_inc(head_q);
            count_d     = count_q - 1'b1;
            first_d     = 1'b0;
            state_d     = ST_T_RD;
          end
        end else begin
          res_o = '{kind: KIND_EXPIRED, port: pend_port_q, seqnum: pend_seq_q, last: 1'b1};
          if (first_q) begin
            we          = 1'b1;
            waddr       = head_q;
            wdata.delta = head_delta;
          end
          res_valid_o = pend_v_q;
          if (!pend_v_q || res_ready_i) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      head_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      head_q   <= head_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q         <= l_d;
    pos_q       <= pos_d;
    before_q    <= before_d;
    acc_q       <= acc_d;
    first_q     <= first_d;
    pend_port_q <= pend_port_d;
    pend_seq_q  <= pend_seq_d;
    kind_q      <= kind_d;
    port_q      <= port_d;
    seq_q       <= seq_d;
    amount_q    <= amount_d;
  end

endmodule

[design/delta_list_timer_queue.sv]
// Timer queue top level: a start item walks the entries before its place, moves the entries
// behind it up one place and writes the new entry (a full store gives only a full result);
// a cancel searches the entries and moves the ones behind its match down; a tick trims the
// head entry and pops the expired ones. Each step reads the single registered-read entry
// memory, and the shift steps write an entry back, so the entry count sets how long the input
// side stays busy, and a stalled output adds its wait. Results leave through an output
// register, so a new item is taken while the last result waits.
module delta_list_timer_queue import dltq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // port[15:0], seqnum[47:16], amount[79:48]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // port_out[15:0], seqnum_out[47:16]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic m_valid_q, m_valid_d;
  res_t m_res_q;

  dltq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_port_i   (s_axis_tdata[15:0]),
    .in_seqnum_i (s_axis_tdata[47:16]),
    .in_amount_i (s_axis_tdata[79:48]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_ready) begin
      m_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.seqnum, m_res_q.port};
  assign m_axis_tuser  = m_res_q.kind;
  assign m_axis_tlast  = m_res_q.last;

endmodule

[design/dltq_checker.sv]
// port-level checks for the timer queue and their bind to the top level
module dltq_checker import dltq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // a real op keeps the input side busy in the following cycle
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == OP_START || s_axis_tuser == OP_CANCEL || s_axis_tuser == OP_TICK)
      |=> !s_axis_tready)
    else $error("input taken again right after an op");

  // only expiry can be followed by more results of the same item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_EXPIRED |-> m_axis_tlast)
    else $error("non-expiry result without last");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_FULL)
    else $error("result kind out of range");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
